### rtl/kdr_pkg.sv
// Shared types and constants for the key debounce and repeat block.
`default_nettype none

package kdr_pkg;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'b0001,
        PH_DEBOUNCE = 4'b0010,
        PH_HELD     = 4'b0100,
        PH_RELEASE  = 4'b1000
    } phase_t;

    localparam logic [1:0] BTN_NONE  = 2'd0;
    localparam logic [1:0] BTN_SET   = 2'd1;
    localparam logic [1:0] BTN_MINUS = 2'd2;
    localparam logic [1:0] BTN_PLUS  = 2'd3;

    localparam logic [1:0] KIND_PRESSED  = 2'd0;
    localparam logic [1:0] KIND_REPEATED = 2'd1;
    localparam logic [1:0] KIND_RELEASED = 2'd2;

    localparam logic CFG_DEBOUNCE = 1'b0;
    localparam logic CFG_REPEAT   = 1'b1;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd20;
    localparam logic [15:0] REPEAT_RESET   = 16'd250;

    localparam int ENTRY_WIDTH = 4;

    typedef struct packed {
        logic       gen;
        logic [1:0] key;
        logic [1:0] kind;
    } event_t;

endpackage

`default_nettype wire

### rtl/kdr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module kdr_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 4
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/kdr_scan.sv
// Key scanner with press debounce, auto-repeat, release debounce and timing registers.
`default_nettype none

module kdr_scan (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire logic           line_set,
    input  wire logic           line_minus,
    input  wire logic           line_plus,
    input  wire logic [31:0]    now_ticks,
    input  wire logic           wr_en,
    input  wire logic           wr_index,
    input  wire logic [15:0]    wr_data,
    output kdr_pkg::event_t     evt
);

    kdr_pkg::phase_t phase_reg, phase_next;
    logic [1:0]      held_reg, held_next;
    logic [31:0]     mark_reg, mark_next;
    logic [15:0]     debounce_reg;
    logic [15:0]     repeat_reg;
    logic [1:0]      code;
    logic [31:0]     elapsed;
    logic            settled;

    always_comb
    begin
        if (!line_set)
        begin
            code = kdr_pkg::BTN_SET;
        end
        else if (!line_minus)
        begin
            code = kdr_pkg::BTN_MINUS;
        end
        else if (!line_plus)
        begin
            code = kdr_pkg::BTN_PLUS;
        end
        else
        begin
            code = kdr_pkg::BTN_NONE;
        end
    end

    assign elapsed = now_ticks - mark_reg;
    assign settled = elapsed >= {16'd0, debounce_reg};

    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        mark_next  = mark_reg;
        evt.gen    = 1'b0;
        evt.key    = kdr_pkg::BTN_NONE;
        evt.kind   = kdr_pkg::KIND_PRESSED;
        unique case (phase_reg)
            kdr_pkg::PH_IDLE:
            begin
                held_next = code;
                if (code != kdr_pkg::BTN_NONE)
                begin
                    mark_next  = now_ticks;
                    phase_next = kdr_pkg::PH_DEBOUNCE;
                end
            end
            kdr_pkg::PH_DEBOUNCE:
            begin
                if (settled)
                begin
                    if (code == held_reg)
                    begin
                        evt.gen    = 1'b1;
                        evt.key    = code;
                        evt.kind   = kdr_pkg::KIND_PRESSED;
                        mark_next  = now_ticks;
                        phase_next = kdr_pkg::PH_HELD;
                    end
                    else
                    begin
                        phase_next = kdr_pkg::PH_IDLE;
                    end
                end
            end
            kdr_pkg::PH_HELD:
            begin
                if (code == kdr_pkg::BTN_NONE)
                begin
                    mark_next  = now_ticks;
                    phase_next = kdr_pkg::PH_RELEASE;
                end
                else if (elapsed > {16'd0, repeat_reg})
                begin
                    evt.gen   = 1'b1;
                    evt.key   = held_reg;
                    evt.kind  = kdr_pkg::KIND_REPEATED;
                    mark_next = now_ticks;
                end
            end
            kdr_pkg::PH_RELEASE:
            begin
                if (settled)
                begin
                    if (code == kdr_pkg::BTN_NONE)
                    begin
                        evt.gen    = 1'b1;
                        evt.key    = held_reg;
                        evt.kind   = kdr_pkg::KIND_RELEASED;
                        phase_next = kdr_pkg::PH_IDLE;
                    end
                    else
                    begin
                        mark_next = now_ticks;
                    end
                end
            end
            default:
            begin
                phase_next = kdr_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= kdr_pkg::PH_IDLE;
            held_reg  <= kdr_pkg::BTN_NONE;
            mark_reg  <= 32'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            mark_reg  <= mark_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= kdr_pkg::DEBOUNCE_RESET;
            repeat_reg   <= kdr_pkg::REPEAT_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                kdr_pkg::CFG_DEBOUNCE: debounce_reg <= wr_data;
                kdr_pkg::CFG_REPEAT:   repeat_reg   <= wr_data;
                default:               debounce_reg <= debounce_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/kdr_fifo.sv
// Event ring queue that keeps one slot empty, with pointers and a RAM for the entries.
`default_nettype none

module kdr_fifo #(
    parameter int QUEUE_SLOTS = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire logic [1:0] push_key,
    input  wire logic [1:0] push_kind,
    input  wire logic       pop,
    output logic            full,
    output logic            empty,
    output logic [1:0]      pop_key,
    output logic [1:0]      pop_kind
);

    localparam int IW = $clog2(QUEUE_SLOTS);
    localparam logic [IW-1:0] LAST = IW'(QUEUE_SLOTS - 1);

    logic [IW-1:0] rd_reg, rd_next;
    logic [IW-1:0] wr_reg, wr_next;
    logic [IW-1:0] wr_inc;
    logic [IW-1:0] rd_inc;
    logic          do_push;
    logic          do_pop;
    logic [kdr_pkg::ENTRY_WIDTH-1:0] rdata;

    assign wr_inc  = (wr_reg == LAST) ? '0 : wr_reg + 1'b1;
    assign rd_inc  = (rd_reg == LAST) ? '0 : rd_reg + 1'b1;
    assign full    = wr_inc == rd_reg;
    assign empty   = wr_reg == rd_reg;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign wr_next = do_push ? wr_inc : wr_reg;
    assign rd_next = do_pop ? rd_inc : rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= '0;
            wr_reg <= '0;
        end
        else
        begin
            rd_reg <= rd_next;
            wr_reg <= wr_next;
        end
    end

    kdr_ram #(
        .WIDTH (kdr_pkg::ENTRY_WIDTH),
        .DEPTH (QUEUE_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (do_push),
        .waddr (wr_reg),
        .wdata ({push_key, push_kind}),
        .re    (do_pop),
        .raddr (rd_reg),
        .rdata (rdata)
    );

    assign pop_key  = rdata[3:2];
    assign pop_kind = rdata[1:0];

endmodule

`default_nettype wire

### rtl/key_debounce_repeat_fifo_unit.sv
// Top level of the three-key debounce and auto-repeat block with its event queue.
`default_nettype none

// Takes one word per cycle while not stalled. A sample word runs the key machine and may
// push a pressed, repeated or released event; a pop word returns the oldest queued event.
// Each word gives one result word, held in the s1 stage during the queue RAM read, then in
// the output register. The stage between them lets a new word in while a result waits.
// The queue holds QUEUE_SLOTS-1 events; an event that finds it full is reported as dropped.
// Timing registers may be written at any idle time through wr_en, wr_index and wr_data.
module key_debounce_repeat_fifo_unit #(
    parameter int QUEUE_SLOTS = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        func,
    input  wire logic        line_set,
    input  wire logic        line_minus,
    input  wire logic        line_plus,
    input  wire logic [31:0] now_ticks,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             entry_valid,
    output logic [1:0]       event_key,
    output logic [1:0]       event_kind,
    output logic             event_pushed,
    output logic             event_dropped,
    input  wire logic        wr_en,
    input  wire logic        wr_index,
    input  wire logic [15:0] wr_data
);

    logic            accept;
    logic            step;
    logic            pop;
    logic            full;
    logic            empty;
    logic [1:0]      pop_key;
    logic [1:0]      pop_kind;
    kdr_pkg::event_t evt;

    logic       s1_valid_reg;
    logic       s1_pop_reg;
    logic       s1_entry_reg;
    logic [1:0] s1_key_reg;
    logic [1:0] s1_kind_reg;
    logic       s1_pushed_reg;
    logic       s1_dropped_reg;
    logic       s1_move;

    logic       out_valid_reg;
    logic       entry_valid_reg, entry_valid_next;
    logic [1:0] event_key_reg, event_key_next;
    logic [1:0] event_kind_reg, event_kind_next;
    logic       event_pushed_reg, event_pushed_next;
    logic       event_dropped_reg, event_dropped_next;

    assign s1_move  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s1_move;
    assign accept   = in_valid && !in_stall;
    assign step     = accept && !func;
    assign pop      = accept && func;

    kdr_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .line_set   (line_set),
        .line_minus (line_minus),
        .line_plus  (line_plus),
        .now_ticks  (now_ticks),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .evt        (evt)
    );

    kdr_fifo #(
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step && evt.gen),
        .push_key  (evt.key),
        .push_kind (evt.kind),
        .pop       (pop),
        .full      (full),
        .empty     (empty),
        .pop_key   (pop_key),
        .pop_kind  (pop_kind)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pop_reg     <= func;
            s1_entry_reg   <= func && !empty;
            s1_key_reg     <= evt.gen ? evt.key : kdr_pkg::BTN_NONE;
            s1_kind_reg    <= evt.gen ? evt.kind : kdr_pkg::KIND_PRESSED;
            s1_pushed_reg  <= !func && evt.gen && !full;
            s1_dropped_reg <= !func && evt.gen && full;
        end
    end

    always_comb
    begin
        if (s1_pop_reg)
        begin
            entry_valid_next   = s1_entry_reg;
            event_key_next     = s1_entry_reg ? pop_key : kdr_pkg::BTN_NONE;
            event_kind_next    = s1_entry_reg ? pop_kind : kdr_pkg::KIND_PRESSED;
            event_pushed_next  = 1'b0;
            event_dropped_next = 1'b0;
        end
        else
        begin
            entry_valid_next   = 1'b0;
            event_key_next     = s1_key_reg;
            event_kind_next    = s1_kind_reg;
            event_pushed_next  = s1_pushed_reg;
            event_dropped_next = s1_dropped_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_valid_reg)
        begin
            entry_valid_reg   <= entry_valid_next;
            event_key_reg     <= event_key_next;
            event_kind_reg    <= event_kind_next;
            event_pushed_reg  <= event_pushed_next;
            event_dropped_reg <= event_dropped_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign entry_valid   = entry_valid_reg;
    assign event_key     = event_key_reg;
    assign event_kind    = event_kind_reg;
    assign event_pushed  = event_pushed_reg;
    assign event_dropped = event_dropped_reg;

endmodule

`default_nettype wire
